### sv/ppp_pkg.sv
// shared types, codes and tables for the proxy v2 preamble parser
// no dependencies
package ppp_pkg;

	localparam logic [7:0] WANTED_TYPE_RESET = 8'hE0;
	localparam int         SIG_LEN           = 12;

	// parse phases
	localparam logic [2:0] PH_SIG    = 3'd0;
	localparam logic [2:0] PH_HDR    = 3'd1;
	localparam logic [2:0] PH_ADDR   = 3'd2;
	localparam logic [2:0] PH_TLVHDR = 3'd3;
	localparam logic [2:0] PH_OTHER  = 3'd4;
	localparam logic [2:0] PH_IDVAL  = 3'd5;
	localparam logic [2:0] PH_UNSCAN = 3'd6;
	localparam logic [2:0] PH_PASS   = 3'd7;

	// byte classes
	localparam logic [2:0] CLS_SIG    = 3'd0;
	localparam logic [2:0] CLS_HDR    = 3'd1;
	localparam logic [2:0] CLS_ADDR   = 3'd2;
	localparam logic [2:0] CLS_TLVHDR = 3'd3;
	localparam logic [2:0] CLS_OTHER  = 3'd4;
	localparam logic [2:0] CLS_ID     = 3'd5;
	localparam logic [2:0] CLS_UNSCAN = 3'd6;
	localparam logic [2:0] CLS_APP    = 3'd7;

	// parse status codes
	localparam logic [2:0] ST_BUSY     = 3'd0;
	localparam logic [2:0] ST_DONE_ID  = 3'd1;
	localparam logic [2:0] ST_DONE_NO  = 3'd2;
	localparam logic [2:0] ST_NOTPROXY = 3'd3;
	localparam logic [2:0] ST_ERROR    = 3'd4;

	// header positions
	localparam logic [3:0] HDR_FIRST  = 4'd12;
	localparam logic [3:0] HDR_FAMILY = 4'd13;
	localparam logic [3:0] HDR_LEN_HI = 4'd14;
	localparam logic [3:0] HDR_LEN_LO = 4'd15;
	localparam logic [3:0] SIG_LAST   = 4'd11;

	// tlv header positions
	localparam logic [3:0] TH_TYPE   = 4'd0;
	localparam logic [3:0] TH_LEN_HI = 4'd1;
	localparam logic [3:0] TH_LEN_LO = 4'd2;

	// register map
	localparam logic [0:0] REG_WANTED   = 1'b0;
	localparam logic [0:0] REG_MISMATCH = 1'b1;

	typedef struct packed {
		logic [7:0] wanted_tlv_type;
		logic       mismatch_is_error;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  hdr_idx;
		logic [15:0] pay_len;
		logic [3:0]  family;
		logic [15:0] pay_pos;
		logic [7:0]  tlv_type;
		logic [15:0] tlv_len;
		logic [15:0] val_rem;
		logic        scan_stop;
		logic        id_found;
		logic [2:0]  held_status;
	} state_t;

	typedef struct packed {
		logic [7:0]  byte_echo;
		logic [2:0]  byte_class;
		logic        id_byte_valid;
		logic        id_last;
		logic [2:0]  parse_status;
		logic [15:0] id_length;
		logic [15:0] payload_length;
		logic [3:0]  address_family;
	} result_t;

	function automatic logic [7:0] sig_byte(input logic [3:0] idx);
		logic [7:0] v;
		unique case (idx)
			4'd0:    v = 8'h0D;
			4'd1:    v = 8'h0A;
			4'd2:    v = 8'h0D;
			4'd3:    v = 8'h0A;
			4'd4:    v = 8'h00;
			4'd5:    v = 8'h0D;
			4'd6:    v = 8'h0A;
			4'd7:    v = 8'h51;
			4'd8:    v = 8'h55;
			4'd9:    v = 8'h49;
			4'd10:   v = 8'h54;
			4'd11:   v = 8'h0A;
			default: v = 8'h0D;
		endcase
		return v;
	endfunction

	// address block bytes per family
	function automatic logic [7:0] addr_block(input logic [3:0] fam);
		logic [7:0] v;
		unique case (fam)
			4'd1:    v = 8'd12;
			4'd2:    v = 8'd36;
			4'd3:    v = 8'd216;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

### sv/ppp_cfg.sv
// apb register file: wanted tlv type and mismatch policy
// depends on ppp_pkg
module ppp_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output ppp_pkg::cfg_t cfg
);
	import ppp_pkg::*;

	logic [7:0] wanted_q;
	logic       mismatch_q;
	logic       wr_en;

	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q   <= WANTED_TYPE_RESET;
			mismatch_q <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WANTED:   wanted_q   <= pwdata[7:0];
				REG_MISMATCH: mismatch_q <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WANTED:   prdata = {24'd0, wanted_q};
			REG_MISMATCH: prdata = {31'd0, mismatch_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg.wanted_tlv_type   = wanted_q;
	assign cfg.mismatch_is_error = mismatch_q;

endmodule

### sv/ppp_core.sv
// parser state registers and the one-byte next-state and result logic
// depends on ppp_pkg
module ppp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  ppp_pkg::cfg_t    cfg,
	input  logic             adv,
	input  logic [7:0]       data_byte,
	input  logic             conn_start,
	input  logic             stream_end,
	output ppp_pkg::result_t res
);
	import ppp_pkg::*;

	state_t st_q;
	state_t nxt;

	// pick the scan phase at the current payload position
	function automatic state_t next_region(input state_t s);
		state_t r;
		logic [15:0] left;
		r    = s;
		left = s.pay_len - s.pay_pos;
		if (s.scan_stop) begin
			r.phase = PH_UNSCAN;
		end else if (left < 16'd3) begin
			r.scan_stop = 1'b1;
			r.phase     = PH_UNSCAN;
		end else begin
			r.phase   = PH_TLVHDR;
			r.hdr_idx = TH_TYPE;
		end
		return r;
	endfunction

	function automatic state_t finish(input state_t s);
		state_t r;
		r             = s;
		r.phase       = PH_PASS;
		r.held_status = s.id_found ? ST_DONE_ID : ST_DONE_NO;
		return r;
	endfunction

	always_comb begin
		state_t      s;
		logic [2:0]  cls;
		logic        idv;
		logic        last;
		logic        need_region;
		logic [15:0] left;
		logic [15:0] blk;

		s           = conn_start ? '0 : st_q;
		cls         = CLS_APP;
		idv         = 1'b0;
		last        = 1'b0;
		need_region = 1'b0;
		left        = '0;
		blk         = '0;

		unique case (s.phase)
			PH_SIG: begin
				cls = CLS_SIG;
				if (data_byte == sig_byte(s.hdr_idx)) begin
					if (s.hdr_idx >= SIG_LAST) begin
						s.phase   = PH_HDR;
						s.hdr_idx = HDR_FIRST;
					end else begin
						s.hdr_idx = s.hdr_idx + 4'd1;
					end
				end else begin
					cls           = CLS_APP;
					s.phase       = PH_PASS;
					s.held_status = cfg.mismatch_is_error ? ST_ERROR : ST_NOTPROXY;
				end
			end
			PH_HDR: begin
				cls = CLS_HDR;
				if (s.hdr_idx == HDR_FAMILY) s.family = data_byte[7:4];
				else if (s.hdr_idx == HDR_LEN_HI) s.pay_len = {data_byte, 8'd0};
				else if (s.hdr_idx == HDR_LEN_LO) s.pay_len = s.pay_len | {8'd0, data_byte};
				if (s.hdr_idx >= HDR_LEN_LO) begin
					s.pay_pos = '0;
					if (s.pay_len == 16'd0) s = finish(s);
					else if (addr_block(s.family) != 8'd0) s.phase = PH_ADDR;
					else s = next_region(s);
				end else begin
					s.hdr_idx = s.hdr_idx + 4'd1;
				end
			end
			PH_ADDR: begin
				cls       = CLS_ADDR;
				blk       = {8'd0, addr_block(s.family)};
				s.pay_pos = s.pay_pos + 16'd1;
				if (s.pay_pos >= s.pay_len) s = finish(s);
				else if (s.pay_pos >= blk) need_region = 1'b1;
			end
			PH_TLVHDR: begin
				cls       = CLS_TLVHDR;
				s.pay_pos = s.pay_pos + 16'd1;
				if (s.hdr_idx == TH_TYPE) begin
					s.tlv_type = data_byte;
					s.hdr_idx  = TH_LEN_HI;
				end else if (s.hdr_idx == TH_LEN_HI) begin
					s.tlv_len = {data_byte, 8'd0};
					s.hdr_idx = TH_LEN_LO;
				end else begin
					left      = s.pay_len - s.pay_pos;
					s.tlv_len = s.tlv_len | {8'd0, data_byte};
					s.hdr_idx = TH_TYPE;
					s.val_rem = s.tlv_len;
					if (s.tlv_len > left) begin
						s.scan_stop = 1'b1;
						s.phase     = PH_UNSCAN;
					end else if (s.tlv_type == cfg.wanted_tlv_type) begin
						s.id_found  = 1'b1;
						s.scan_stop = 1'b1;
						s.phase     = (s.tlv_len != 16'd0) ? PH_IDVAL : PH_UNSCAN;
					end else if (s.tlv_len != 16'd0) begin
						s.phase = PH_OTHER;
					end else begin
						need_region = 1'b1;
					end
				end
				if (s.pay_pos >= s.pay_len) begin
					s           = finish(s);
					need_region = 1'b0;
				end
			end
			PH_OTHER, PH_IDVAL: begin
				if (s.phase == PH_IDVAL) begin
					cls  = CLS_ID;
					idv  = 1'b1;
					last = (s.val_rem == 16'd1);
				end else begin
					cls = CLS_OTHER;
				end
				s.pay_pos = s.pay_pos + 16'd1;
				if (s.val_rem != 16'd0) s.val_rem = s.val_rem - 16'd1;
				if (s.pay_pos >= s.pay_len) s = finish(s);
				else if (s.val_rem == 16'd0) need_region = 1'b1;
			end
			PH_UNSCAN: begin
				cls       = CLS_UNSCAN;
				s.pay_pos = s.pay_pos + 16'd1;
				if (s.pay_pos >= s.pay_len) s = finish(s);
			end
			default: begin
				cls = CLS_APP;
			end
		endcase

		if (need_region) s = next_region(s);

		if (stream_end && (s.phase != PH_PASS)) begin
			s.phase       = PH_PASS;
			s.held_status = ST_ERROR;
		end

		nxt                = s;
		res.byte_echo      = data_byte;
		res.byte_class     = cls;
		res.id_byte_valid  = idv;
		res.id_last        = last;
		res.parse_status   = (s.phase == PH_PASS) ? s.held_status : ST_BUSY;
		res.id_length      = s.id_found ? s.tlv_len : 16'd0;
		res.payload_length = s.pay_len;
		res.address_family = s.family;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= nxt;
		end
	end

endmodule

### sv/proxy_v2_preamble_parser.sv
// top level of the proxy v2 preamble parser: input beat register, result register
// depends on ppp_pkg, ppp_cfg, ppp_core
//
// One result beat per input beat: every connection byte comes back with its
// class (signature, header, address, tlv header, other tlv value, identifier
// value, unscanned payload or application data), the parse status, and the
// header fields seen so far. A beat with conn_start set restarts the parser
// before its byte is taken; stream_end before the preamble completes reports
// a truncation error. Throughput is one byte per clock while the output is not
// stalled: an accepted beat sits in the input register while the parse logic
// updates the state and forms the result, which lands in the output register
// and raises out_valid as the beat leaves the input register. The input side
// keeps accepting while a result waits, and stalls only when both registers
// are full and the output is stalled. Registers wanted_tlv_type (address 0,
// reset 0xE0) and mismatch_is_error (address 4, reset 0) are written over the
// apb port; the user must write them only while no beat is in flight, as the
// block does not enforce it. They survive conn_start.
module proxy_v2_preamble_parser (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        conn_start,
	input  logic        stream_end,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_echo,
	output logic [2:0]  byte_class,
	output logic        id_byte_valid,
	output logic        id_last,
	output logic [2:0]  parse_status,
	output logic [15:0] id_length,
	output logic [15:0] payload_length,
	output logic [3:0]  address_family
);
	import ppp_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_q;

	// input beat register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;

	logic out_valid_q;
	logic adv;      // s1 beat moves into the result register
	logic take_in;

	assign pready = 1'b1;

	ppp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// result register frees up when empty or being taken this edge
	assign adv      = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign take_in  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1  <= data_byte;
			start_s1 <= conn_start;
			end_s1   <= stream_end;
		end
	end

	// parse state advances exactly once per beat leaving s1
	ppp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.adv        (adv),
		.data_byte  (byte_s1),
		.conn_start (start_s1),
		.stream_end (end_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_echo      = res_q.byte_echo;
	assign byte_class     = res_q.byte_class;
	assign id_byte_valid  = res_q.id_byte_valid;
	assign id_last        = res_q.id_last;
	assign parse_status   = res_q.parse_status;
	assign id_length      = res_q.id_length;
	assign payload_length = res_q.payload_length;
	assign address_family = res_q.address_family;

	// last identifier byte is always a flagged identifier byte
	a_id_last_cls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && id_last |-> id_byte_valid && (byte_class == CLS_ID))
		else $error("id_last outside identifier value");

	// input only stalls when both registers hold beats and output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a full pipeline");

	// a beat leaving s1 shows up as a result next cycle
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced beat lost");

	// a flagged identifier byte means the identifier tlv was found
	a_id_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && id_byte_valid |-> (id_length != 16'd0))
		else $error("identifier byte without identifier length");

endmodule

### tb/testbench.sv
// self-checking testbench for proxy_v2_preamble_parser: byte stream in, classified echo out
// depends on ppp_pkg and the parser rtl; holds its own model of the preamble parse
`timescale 1ns / 100ps

module testbench;
	import ppp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	// the twelve signature bytes, first byte at index 0
	localparam logic [0:11][7:0] SIGNATURE = {8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D,
		8'h0A, 8'h51, 8'h55, 8'h49, 8'h54, 8'h0A};

	// one pending input beat
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       tail;
	} conn_byte_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte  = '0;
	logic        conn_start = 1'b0;
	logic        stream_end = 1'b0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [7:0]  byte_echo;
	logic [2:0]  byte_class;
	logic        id_byte_valid;
	logic        id_last;
	logic [2:0]  parse_status;
	logic [15:0] id_length;
	logic [15:0] payload_length;
	logic [3:0]  address_family;

	proxy_v2_preamble_parser dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.conn_start(conn_start), .stream_end(stream_end),
		.out_valid(out_valid), .out_stall(out_stall), .byte_echo(byte_echo),
		.byte_class(byte_class), .id_byte_valid(id_byte_valid), .id_last(id_last),
		.parse_status(parse_status), .id_length(id_length),
		.payload_length(payload_length), .address_family(address_family)
	);

	conn_byte_t byte_queue[$];    // beats waiting for the driver
	result_t    echo_queue[$];    // predicted echoes, oldest first
	cfg_t       regs;             // register values as last written
	state_t     pstate;           // model of the parser state
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         pushed        = 0;
	int         mismatches    = 0;
	int         result_no     = 0;
	int         cycle_count   = 0;
	logic       beat_taken    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// model of the preamble parse
	// ---------------------------------------------------------------

	// address block length per family nibble
	function automatic int addr_bytes(input logic [3:0] fam);
		case (fam)
			4'd1:    return 12;
			4'd2:    return 36;
			4'd3:    return 216;
			default: return 0;
		endcase
	endfunction

	// preamble consumed: status depends on whether the identifier was seen
	function automatic void close_preamble();
		pstate.phase = PH_PASS;
		pstate.held_status = pstate.id_found ? ST_DONE_ID : ST_DONE_NO;
	endfunction

	// advance the model by one byte and return the echo it should produce
	function automatic result_t parse_byte(input logic [7:0] b, input logic start,
			input logic tail);
		result_t r;
		logic    seek;
		int      left;
		r = '0;
		r.byte_echo = b;
		r.byte_class = CLS_APP;
		seek = 1'b0;
		if (start) begin
			pstate = '0;
			pstate.phase = PH_SIG;
		end
		case (pstate.phase)
			PH_SIG: begin
				r.byte_class = CLS_SIG;
				if (b == SIGNATURE[pstate.hdr_idx]) begin
					if (pstate.hdr_idx >= SIG_LAST) begin
						pstate.phase = PH_HDR;
						pstate.hdr_idx = HDR_FIRST;
					end else begin
						pstate.hdr_idx = pstate.hdr_idx + 4'd1;
					end
				end else begin
					// first wrong signature byte already counts as application data
					r.byte_class = CLS_APP;
					pstate.phase = PH_PASS;
					pstate.held_status = regs.mismatch_is_error ? ST_ERROR : ST_NOTPROXY;
				end
			end
			PH_HDR: begin
				r.byte_class = CLS_HDR;
				if (pstate.hdr_idx == HDR_FAMILY)
					pstate.family = b[7:4];
				else if (pstate.hdr_idx == HDR_LEN_HI)
					pstate.pay_len = {b, 8'h00};
				else if (pstate.hdr_idx == HDR_LEN_LO)
					pstate.pay_len[7:0] = b;
				if (pstate.hdr_idx >= HDR_LEN_LO) begin
					pstate.pay_pos = '0;
					if (pstate.pay_len == 0)
						close_preamble();
					else if (addr_bytes(pstate.family) > 0)
						pstate.phase = PH_ADDR;
					else
						seek = 1'b1;
				end else begin
					pstate.hdr_idx = pstate.hdr_idx + 4'd1;
				end
			end
			PH_ADDR: begin
				r.byte_class = CLS_ADDR;
				pstate.pay_pos = pstate.pay_pos + 16'd1;
				if (pstate.pay_pos >= pstate.pay_len)
					close_preamble();
				else if (int'(pstate.pay_pos) >= addr_bytes(pstate.family))
					seek = 1'b1;
			end
			PH_TLVHDR: begin
				r.byte_class = CLS_TLVHDR;
				pstate.pay_pos = pstate.pay_pos + 16'd1;
				if (pstate.hdr_idx == TH_TYPE) begin
					pstate.tlv_type = b;
					pstate.hdr_idx = TH_LEN_HI;
				end else if (pstate.hdr_idx == TH_LEN_HI) begin
					pstate.tlv_len = {b, 8'h00};
					pstate.hdr_idx = TH_LEN_LO;
				end else begin
					left = int'(pstate.pay_len) - int'(pstate.pay_pos);
					pstate.tlv_len[7:0] = b;
					pstate.hdr_idx = TH_TYPE;
					pstate.val_rem = pstate.tlv_len;
					if (int'(pstate.tlv_len) > left) begin
						// tlv runs past the payload
						pstate.scan_stop = 1'b1;
						pstate.phase = PH_UNSCAN;
					end else if (pstate.tlv_type == regs.wanted_tlv_type) begin
						pstate.id_found = 1'b1;
						pstate.scan_stop = 1'b1;
						pstate.phase = (pstate.tlv_len > 0) ? PH_IDVAL : PH_UNSCAN;
					end else if (pstate.tlv_len > 0) begin
						pstate.phase = PH_OTHER;
					end else begin
						seek = 1'b1;
					end
				end
				if (pstate.pay_pos >= pstate.pay_len) begin
					close_preamble();
					seek = 1'b0;
				end
			end
			PH_OTHER, PH_IDVAL: begin
				if (pstate.phase == PH_IDVAL) begin
					r.byte_class = CLS_ID;
					r.id_byte_valid = 1'b1;
					r.id_last = (pstate.val_rem == 1);
				end else begin
					r.byte_class = CLS_OTHER;
				end
				pstate.pay_pos = pstate.pay_pos + 16'd1;
				if (pstate.val_rem > 0)
					pstate.val_rem = pstate.val_rem - 16'd1;
				if (pstate.pay_pos >= pstate.pay_len)
					close_preamble();
				else if (pstate.val_rem == 0)
					seek = 1'b1;
			end
			PH_UNSCAN: begin
				r.byte_class = CLS_UNSCAN;
				pstate.pay_pos = pstate.pay_pos + 16'd1;
				if (pstate.pay_pos >= pstate.pay_len)
					close_preamble();
			end
			default: ;
		endcase
		// pick what the next payload byte belongs to
		if (seek) begin
			if (pstate.scan_stop) begin
				pstate.phase = PH_UNSCAN;
			end else if (int'(pstate.pay_len) - int'(pstate.pay_pos) < 3) begin
				pstate.scan_stop = 1'b1;
				pstate.phase = PH_UNSCAN;
			end else begin
				pstate.phase = PH_TLVHDR;
				pstate.hdr_idx = TH_TYPE;
			end
		end
		// stream ended before the preamble did
		if (tail && pstate.phase != PH_PASS) begin
			pstate.phase = PH_PASS;
			pstate.held_status = ST_ERROR;
		end
		r.parse_status = (pstate.phase == PH_PASS) ? pstate.held_status : ST_BUSY;
		r.id_length = pstate.id_found ? pstate.tlv_len : 16'h0000;
		r.payload_length = pstate.pay_len;
		r.address_family = pstate.family;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	// one line per mismatch
	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches = mismatches + 1;
	endtask

	task automatic check_field(input string name, input int seen, input int want);
		if (seen != want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				result_no, name, seen, want));
	endtask

	// monitor: predict on every accepted input beat, compare every accepted result beat
	always @(posedge clk) begin : monitor
		result_t seen;
		result_t want;
		beat_taken = arst_n && in_valid && !in_stall;
		if (beat_taken)
			echo_queue.push_back(parse_byte(data_byte, conn_start, stream_end));
		if (arst_n && out_valid && !out_stall) begin
			seen = {byte_echo, byte_class, id_byte_valid, id_last, parse_status,
				id_length, payload_length, address_family};
			if (echo_queue.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					result_no));
			end else begin
				want = echo_queue.pop_front();
				check_field("byte_echo", int'(seen.byte_echo), int'(want.byte_echo));
				check_field("byte_class", int'(seen.byte_class), int'(want.byte_class));
				check_field("id_byte_valid", int'(seen.id_byte_valid),
					int'(want.id_byte_valid));
				check_field("id_last", int'(seen.id_last), int'(want.id_last));
				check_field("parse_status", int'(seen.parse_status),
					int'(want.parse_status));
				check_field("id_length", int'(seen.id_length), int'(want.id_length));
				check_field("payload_length", int'(seen.payload_length),
					int'(want.payload_length));
				check_field("address_family", int'(seen.address_family),
					int'(want.address_family));
			end
			result_no = result_no + 1;
		end
	end

	// ---------------------------------------------------------------
	// driving
	// ---------------------------------------------------------------

	// driver: a beat holds until taken, then the next one goes out unless the sender idles
	always @(negedge clk) begin : driver
		conn_byte_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			if (!in_valid || beat_taken) begin
				if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nb = byte_queue.pop_front();
					in_valid <= 1'b1;
					data_byte <= nb.data;
					conn_start <= nb.start;
					stream_end <= nb.tail;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic push_beat(input logic [7:0] data, input logic start, input logic tail);
		conn_byte_t nb;
		nb.data = data;
		nb.start = start;
		nb.tail = tail;
		byte_queue.push_back(nb);
		pushed = pushed + 1;
	endtask

	// one connection: mostly well-formed preambles with random content,
	// some broken signatures, some plain noise
	task automatic gen_connection();
		logic [7:0]  conn[$];
		logic [7:0]  pay[$];
		logic [7:0]  ttype;
		logic [15:0] tlen;
		logic [15:0] plen;
		logic [3:0]  fam;
		logic [3:0]  lo;
		int          kind;
		int          pick;
		int          ablk;
		int          ntlv;
		int          n;
		int          cut;
		int          i;
		bit          overrun;
		bit          oversize;
		bit          ended;
		kind = $urandom_range(0, 19);
		ended = 1'b0;
		if (kind < 2) begin
			// noise with random start and end marks
			repeat ($urandom_range(1, 6))
				push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
					$urandom_range(0, 3) == 0);
		end else begin
			for (i = 0; i < SIG_LEN; i++)
				conn.push_back(SIGNATURE[i]);
			if (kind < 4) begin
				// signature goes wrong at a random byte
				cut = $urandom_range(0, SIG_LEN - 1);
				conn[cut] = conn[cut] ^ 8'($urandom_range(1, 255));
				while (conn.size() > cut + 1)
					void'(conn.pop_back());
				repeat ($urandom_range(0, 3))
					conn.push_back(8'($urandom_range(0, 255)));
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 5)
					fam = 4'd0;
				else if (pick < 12)
					fam = 4'd1;
				else if (pick < 17)
					fam = 4'd2;
				else if (pick == 17)
					fam = 4'd3;
				else
					fam = 4'($urandom_range(4, 15));
				lo = 4'($urandom_range(0, 15));
				ablk = addr_bytes(fam);
				overrun = 1'b0;
				if (ablk > 0 && $urandom_range(0, 9) == 0) begin
					// payload no longer than the address block
					repeat ($urandom_range(1, ablk))
						pay.push_back(8'($urandom_range(0, 255)));
				end else begin
					repeat (ablk)
						pay.push_back(8'($urandom_range(0, 255)));
					ntlv = $urandom_range(0, 3);
					for (i = 0; i < ntlv && !overrun; i++) begin
						ttype = 8'($urandom_range(0, 255));
						if ($urandom_range(0, 2) != 0)
							ttype = regs.wanted_tlv_type;
						if ($urandom_range(0, 7) == 0) begin
							overrun = 1'b1;
							tlen = 16'($urandom_range(3, 65535));
						end else begin
							tlen = 16'($urandom_range(0, 6));
						end
						pay.push_back(ttype);
						pay.push_back(tlen[15:8]);
						pay.push_back(tlen[7:0]);
						n = overrun ? $urandom_range(0, 2) : int'(tlen);
						repeat (n)
							pay.push_back(8'($urandom_range(0, 255)));
					end
					// tail too short to hold a tlv header
					if (!overrun && $urandom_range(0, 3) == 0)
						repeat ($urandom_range(1, 2))
							pay.push_back(8'($urandom_range(0, 255)));
				end
				plen = 16'(pay.size());
				oversize = ($urandom_range(0, 11) == 0);
				if (oversize)
					plen = 16'hFFFF;
				conn.push_back(8'($urandom_range(0, 255)));
				conn.push_back({fam, lo});
				conn.push_back(plen[15:8]);
				conn.push_back(plen[7:0]);
				foreach (pay[k])
					conn.push_back(pay[k]);
				repeat ($urandom_range(0, 4))
					conn.push_back(8'($urandom_range(0, 255)));
				// connection closes early
				if (oversize || $urandom_range(0, 5) == 0) begin
					cut = $urandom_range(0, conn.size() - 1);
					while (conn.size() > cut + 1)
						void'(conn.pop_back());
					ended = 1'b1;
				end
			end
			if ($urandom_range(0, 1) == 0)
				ended = 1'b1;
			for (i = 0; i < conn.size(); i++)
				push_beat(conn[i], i == 0, ended && i == conn.size() - 1);
			// stray bytes after the end, no restart
			if (ended && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2))
					push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end
	endtask

	task automatic fill_connections(input int count);
		pushed = 0;
		while (pushed < count)
			gen_connection();
	endtask

	// nothing queued, nothing on the wire, nothing outstanding
	task automatic wait_drain();
		while (byte_queue.size() != 0 || in_valid || echo_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// registers change only with the parser drained
	task automatic set_regs(input logic [7:0] wanted, input logic mism);
		apb_write({REG_WANTED, 2'b00}, {24'h0, wanted});
		regs.wanted_tlv_type = wanted;
		apb_write({REG_MISMATCH, 2'b00}, {31'h0, mism});
		regs.mismatch_is_error = mism;
	endtask

	// ---------------------------------------------------------------
	// run sequence
	// ---------------------------------------------------------------
	initial begin
		int i;
		regs.wanted_tlv_type = WANTED_TYPE_RESET;
		regs.mismatch_is_error = 1'b0;
		pstate = '0;
		pstate.phase = PH_SIG;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender idles a little, receiver half the time
		set_regs(WANTED_TYPE_RESET, 1'b0);
		send_idle_pct = 8;
		recv_idle_pct = 50;
		// broken signature, then a byte in passthrough
		push_beat(8'h0D, 1'b1, 1'b0);
		push_beat(8'h0A, 1'b0, 1'b0);
		push_beat(8'hFF, 1'b0, 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		// unspecified family, one empty identifier tlv, one unscanned byte,
		// then application data that ends the stream
		for (i = 0; i < SIG_LEN; i++)
			push_beat(SIGNATURE[i], i == 0, 1'b0);
		push_beat(8'h21, 1'b0, 1'b0);
		push_beat(8'h0F, 1'b0, 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		push_beat(8'h04, 1'b0, 1'b0);
		push_beat(WANTED_TYPE_RESET, 1'b0, 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		push_beat(8'hFF, 1'b0, 1'b0);
		push_beat(8'h55, 1'b0, 1'b1);
		fill_connections(135);

		// each drain below holds the sender until every result is back
		wait_drain();
		set_regs(8'h00, 1'b1);
		send_idle_pct = 50;
		recv_idle_pct = 8;
		fill_connections(135);

		wait_drain();
		set_regs(8'hFF, 1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_connections(65);

		wait_drain();
		set_regs(8'($urandom_range(0, 255)), 1'b1);
		fill_connections(65);

		wait_drain();
		// allow for the two-register pipeline and any stray beat
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
